// ===== hdl/mod_pattern_cell_decoder_defines.svh =====
// Assertion helpers shared by the pattern cell decoder RTL.
`ifndef MOD_PATTERN_CELL_DECODER_DEFINES_SVH
`define MOD_PATTERN_CELL_DECODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MPCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MPCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/mpcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mpcd_pkg;

   // Period table geometry.
   localparam int TABLE_ENTRIES = 96;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // Field widths.
   localparam int NOTE_W   = 7;
   localparam int INDEX_W  = 7;
   localparam int PERIOD_W = 12;
   localparam int FMT_W    = 3;

   // File format codes.
   localparam logic [FMT_W-1:0] FMT_STANDARD   = 3'd0;
   localparam logic [FMT_W-1:0] FMT_STREK4     = 3'd1;
   localparam logic [FMT_W-1:0] FMT_STREK8     = 3'd2;
   localparam logic [FMT_W-1:0] FMT_MULTICHAN  = 3'd3;
   localparam logic [FMT_W-1:0] FMT_NTRACK     = 3'd4;
   localparam logic [FMT_W-1:0] FMT_NTRACK_SPC = 3'd5;

   // Input item kinds.
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // Effect command codes.
   localparam logic [3:0] FX_NONE       = 4'h0;
   localparam logic [3:0] FX_PORTA_UP   = 4'h1;
   localparam logic [3:0] FX_PORTA_DOWN = 4'h2;
   localparam logic [3:0] FX_TONE_PORTA = 4'h3;
   localparam logic [3:0] FX_VIBRATO    = 4'h4;
   localparam logic [3:0] FX_TONE_VOL   = 4'h5;
   localparam logic [3:0] FX_VIB_VOL    = 4'h6;
   localparam logic [3:0] FX_VOL_SLIDE  = 4'hA;
   localparam logic [3:0] FX_VOLUME     = 4'hC;
   localparam logic [3:0] FX_BREAK      = 4'hD;
   localparam logic [3:0] FX_EXTENDED   = 4'hE;
   localparam logic [3:0] FX_SPEED      = 4'hF;

   // Parameter limits and empty extended sub-commands.
   localparam logic [7:0] VOLUME_MAX   = 8'd64;
   localparam logic [7:0] SPEED_MAX    = 8'h1F;
   localparam logic [7:0] EXT_FINE_UP  = 8'h10;
   localparam logic [7:0] EXT_FINE_DN  = 8'h20;
   localparam logic [7:0] EXT_FVOL_UP  = 8'hA0;
   localparam logic [7:0] EXT_FVOL_DN  = 8'hB0;

   typedef struct packed {
      logic [3:0] effect;
      logic [7:0] param;
   } fx_type;

   // Apply the generic effect rules, then the fixes of the file format.
   function automatic fx_type clean_effect(input logic [3:0] fx, input logic [7:0] arg,
                                           input logic [FMT_W-1:0] fmt);
      fx_type r;
      r.effect = fx;
      r.param  = arg;
      unique case (fx)
         FX_VOLUME: begin
            if (arg > VOLUME_MAX) r.param = VOLUME_MAX;
         end
         FX_PORTA_UP, FX_PORTA_DOWN, FX_VOL_SLIDE: begin
            if (arg == 8'd0) r.effect = FX_NONE;
         end
         FX_TONE_VOL: begin
            if (arg == 8'd0) r.effect = FX_TONE_PORTA;
         end
         FX_VIB_VOL: begin
            if (arg == 8'd0) r.effect = FX_VIBRATO;
         end
         FX_EXTENDED: begin
            if (arg == EXT_FINE_UP || arg == EXT_FINE_DN ||
                arg == EXT_FVOL_UP || arg == EXT_FVOL_DN) begin
               r.effect = FX_NONE;
               r.param  = 8'd0;
            end
         end
         default: ;
      endcase

      if (fmt == FMT_NTRACK || fmt == FMT_NTRACK_SPC) begin
         if (r.effect == FX_BREAK) r.param = 8'd0;
         if (r.effect == FX_SPEED && r.param == 8'd0) r.effect = FX_NONE;
      end else if (fmt == FMT_STREK4 || fmt == FMT_STREK8) begin
         if (r.effect == FX_EXTENDED) begin
            r.effect = FX_NONE;
            r.param  = 8'd0;
         end
         if (r.effect == FX_SPEED && r.param > SPEED_MAX) r.param = SPEED_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mod_pattern_cell_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pattern cell decoder. A load word (req_kind = 0) writes one entry of the
// period table; indexes past the table end are dropped and give no response.
// A decode word (req_kind = 1) splits the 4-byte cell into instrument and
// effect, cleans the effect under the format set through csr_mod_format, and
// finds the note by walking the period table from entry 0 through the single
// table read port, one entry per cycle, against one shared 12-bit compare.
// The first entry that the cell period is at least gives note = index + 1,
// and no match gives note 0. A decode word keeps the input stalled from its
// accepting edge through the first table read (ST_FETCH) and the walk
// (ST_WALK), which examines 1 to 96 entries; the walk holds on its last
// entry for as long as an earlier response still waits in the output
// register under rsp_stall. The response then sits in an output register
// while the next word is taken. Entries must be loaded before a decode reads
// them: an unwritten entry returns an undefined note. Write csr_mod_format
// only while no word is in flight.
`include "mod_pattern_cell_decoder_defines.svh"

module mod_pattern_cell_decoder
   import mpcd_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   // request channel
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_kind,
   input  wire  [INDEX_W-1:0]  req_table_index,
   input  wire  [PERIOD_W-1:0] req_table_period,
   input  wire  [31:0]         req_cell_word,
   // response channel
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [NOTE_W-1:0]   rsp_note,
   output logic [7:0]          rsp_instrument,
   output logic [3:0]          rsp_effect,
   output logic [7:0]          rsp_effect_param,
   // configuration write channel
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [FMT_W-1:0]    csr_mod_format
);

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_WALK} state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [31:0]         cell_ff, cell_in;
   logic [FMT_W-1:0]    fmt_ff, fmt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NOTE_W-1:0]   note_ff, note_in;
   logic [7:0]          instr_ff, instr_in;
   logic [3:0]          effect_ff, effect_in;
   logic [7:0]          param_ff, param_in;

   // period table
   logic [PERIOD_W-1:0] table_mem [TABLE_ENTRIES];
   logic [PERIOD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                tbl_we;

   logic                req_take;
   logic                decode_take;
   logic [PERIOD_W-1:0] cell_period;
   logic                match;
   logic                at_last;
   logic                advance;
   logic                finish;
   logic                rsp_load;
   fx_type              fx_clean;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign decode_take = req_take && (req_kind == KIND_DECODE);
   assign csr_ready   = 1'b1;

   // Cell period is the low nibble of byte 0 joined with byte 1.
   assign cell_period = {cell_ff[27:24], cell_ff[23:16]};

   // Shared compare: rd_data_ff holds the entry at idx_ff while walking.
   assign match    = (cell_period >= rd_data_ff);
   assign at_last  = (idx_ff == LAST_IDX);
   assign finish   = (state_ff == ST_WALK) && (match || at_last);
   assign advance  = (state_ff == ST_WALK) && !match && !at_last;
   assign rsp_load = finish && (!rsp_valid_ff || !rsp_stall);

   // Read ahead one entry while advancing; otherwise reread the current one.
   assign rd_addr = advance ? idx_ff + IDX_W'(1) : idx_ff;

   assign tbl_we = req_take && (req_kind == KIND_LOAD) &&
                   ({1'b0, req_table_index} < (INDEX_W + 1)'(TABLE_ENTRIES));

   assign fx_clean = clean_effect(cell_ff[11:8], cell_ff[7:0], fmt_ff);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[req_table_index[IDX_W-1:0]] <= req_table_period;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cell_in      = cell_ff;
      fmt_in       = fmt_ff;
      rsp_valid_in = rsp_valid_ff;
      note_in      = note_ff;
      instr_in     = instr_ff;
      effect_in    = effect_ff;
      param_in     = param_ff;

      if (csr_valid && csr_ready) fmt_in = csr_mod_format;

      // drop the response once the sink takes it
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (decode_take) begin
               cell_in  = req_cell_word;
               idx_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // first table read is in flight
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (advance) begin
               idx_in = idx_ff + IDX_W'(1);
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               note_in      = match ? NOTE_W'(int'(idx_ff) + 1) : '0;
               instr_in     = {cell_ff[31:28], cell_ff[15:12]};
               effect_in    = fx_clean.effect;
               param_in     = fx_clean.param;
               state_in     = ST_IDLE;
            end
            // otherwise hold until the output register frees up
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         fmt_ff       <= FMT_STANDARD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fmt_ff       <= fmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cell_ff   <= cell_in;
      note_ff   <= note_in;
      instr_ff  <= instr_in;
      effect_ff <= effect_in;
      param_ff  <= param_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_note         = note_ff;
   assign rsp_instrument   = instr_ff;
   assign rsp_effect       = effect_ff;
   assign rsp_effect_param = param_ff;

   `MPCD_ASSERT(a_walk_in_range, (state_ff == ST_WALK) |-> (idx_ff <= LAST_IDX), "walk past end")
   `MPCD_ASSERT(a_walk_step, advance |=> (idx_ff == $past(idx_ff) + IDX_W'(1)), "walk skipped")
   `MPCD_ASSERT(a_decode_starts, decode_take |=> (state_ff == ST_FETCH), "no walk start")
   `MPCD_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff == ST_WALK), "stray rsp")
   `MPCD_ASSERT_ALWAYS(a_reset, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset failed")

endmodule

`default_nettype wire
